FILE: rtl/cbm_pkg.sv
package cbm_pkg;

  // Default sizes
  localparam int unsigned WORK_RAM_BYTES_DEF = 8192;
  localparam int unsigned PRG_BANKS_8K_DEF   = 16;
  localparam int unsigned CHR_BANKS_4K_DEF   = 32;

  // Configuration port
  localparam int unsigned CFG_AW = 3;
  localparam int unsigned CFG_DW = 32;
  localparam logic REG_CHR_MASK = 1'b0;
  localparam logic REG_PRG_MASK = 1'b1;
  localparam logic [4:0] CHR_MASK_RST = 5'd31;
  localparam logic [3:0] PRG_MASK_RST = 4'd15;

  // Bus commands
  typedef enum logic [1:0] {
    CMD_CPU_RD = 2'd0,
    CMD_CPU_WR = 2'd1,
    CMD_PPU    = 2'd2
  } cmd_t;

  // CPU 4K pages
  localparam logic [3:0] PAGE_WRAM0   = 4'h6;
  localparam logic [3:0] PAGE_WRAM1   = 4'h7;
  localparam logic [3:0] PAGE_PRG_SEL = 4'hA;
  localparam logic [3:0] PAGE_CHR0    = 4'hB;
  localparam logic [3:0] PAGE_CHR1    = 4'hC;
  localparam logic [3:0] PAGE_CHR2    = 4'hD;
  localparam logic [3:0] PAGE_CHR3    = 4'hE;
  localparam logic [3:0] PAGE_MIRROR  = 4'hF;

  // Fixed-bank offset: slots 1..3 map to mask-2, mask-1, mask
  localparam logic [3:0] PRG_FIXED_BIAS = 4'd3;

  // PPU address map
  localparam logic [13:0] PPU_NT_BASE    = 14'h2000;
  localparam logic [13:0] PPU_PAL_BASE   = 14'h3F00;
  localparam logic [13:0] PPU_TILE_MASK  = 14'h3FF0;
  localparam logic [13:0] TILE_W0_FD     = 14'h0FD0;
  localparam logic [13:0] TILE_W0_FE     = 14'h0FE0;
  localparam logic [13:0] TILE_W1_FD     = 14'h1FD0;
  localparam logic [13:0] TILE_W1_FE     = 14'h1FE0;

  localparam logic [7:0] OPEN_BUS = 8'hFF;

  typedef struct packed {
    logic [1:0]  command;
    logic [15:0] cpu_address;
    logic [7:0]  write_data;
    logic [13:0] ppu_address;
  } in_beat_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic        prg_rom_valid;
    logic [16:0] prg_rom_address;
    logic        chr_rom_valid;
    logic [16:0] chr_rom_address;
    logic        nametable_valid;
    logic [10:0] nametable_address;
  } out_beat_t;

  // Mapper register file contents
  typedef struct packed {
    logic [4:0]      chr_mask;
    logic [3:0]      prg_mask;
    logic [3:0]      prg_bank;
    logic [3:0][4:0] chr_bank;
    logic            mirror_h;
    logic [1:0]      latch;
  } map_state_t;

  // Register / latch update request from the decoder
  typedef struct packed {
    logic       reg_we;
    logic [3:0] page;
    logic [7:0] data;
    logic       latch_we;
    logic       latch_sel;
    logic       latch_val;
  } map_upd_t;

endpackage

FILE: rtl/cbm_ram.sv
module cbm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = cbm_pkg::WORK_RAM_BYTES_DEF
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Single port; read data holds until the next read
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem_r[addr] <= wdata;
      end else begin
        rdata_r <= mem_r[addr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/cbm_regs.sv
module cbm_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  // config port
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [cbm_pkg::CFG_AW-1:0]  cfg_paddr,
  input  logic [cbm_pkg::CFG_DW-1:0]  cfg_pwdata,
  output logic [cbm_pkg::CFG_DW-1:0]  cfg_prdata,
  output logic                        cfg_pready,
  // bus-side updates
  input  logic                        upd_en,
  input  cbm_pkg::map_upd_t           upd,
  output cbm_pkg::map_state_t         state
);

  cbm_pkg::map_state_t st_r;
  logic                cfg_we;
  logic                cfg_sel;

  assign cfg_pready = 1'b1;
  assign cfg_sel    = cfg_paddr[2];
  assign cfg_we     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  // Register readback
  always_comb begin
    unique case (cfg_sel)
      cbm_pkg::REG_CHR_MASK: cfg_prdata = cbm_pkg::CFG_DW'(st_r.chr_mask);
      cbm_pkg::REG_PRG_MASK: cfg_prdata = cbm_pkg::CFG_DW'(st_r.prg_mask);
      default:               cfg_prdata = '0;
    endcase
  end

  // Masks from config, banks, mirroring and latches from the bus
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.chr_mask <= cbm_pkg::CHR_MASK_RST;
      st_r.prg_mask <= cbm_pkg::PRG_MASK_RST;
      st_r.prg_bank <= '0;
      st_r.chr_bank <= '0;
      st_r.mirror_h <= 1'b0;
      st_r.latch    <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_sel)
          cbm_pkg::REG_CHR_MASK: st_r.chr_mask <= cfg_pwdata[4:0];
          cbm_pkg::REG_PRG_MASK: st_r.prg_mask <= cfg_pwdata[3:0];
          default: ;
        endcase
      end
      if (upd_en && upd.reg_we) begin
        unique case (upd.page)
          cbm_pkg::PAGE_PRG_SEL: st_r.prg_bank <= upd.data[3:0];
          cbm_pkg::PAGE_CHR0,
          cbm_pkg::PAGE_CHR1,
          cbm_pkg::PAGE_CHR2,
          cbm_pkg::PAGE_CHR3:
            st_r.chr_bank[2'(upd.page - cbm_pkg::PAGE_CHR0)] <= upd.data[4:0];
          cbm_pkg::PAGE_MIRROR:  st_r.mirror_h <= upd.data[0];
          default: ;
        endcase
      end
      if (upd_en && upd.latch_we) begin
        st_r.latch[upd.latch_sel] <= upd.latch_val;
      end
    end
  end

  assign state = st_r;

endmodule

FILE: rtl/cbm_xlat.sv
module cbm_xlat #(
  parameter int unsigned WORK_RAM_BYTES = cbm_pkg::WORK_RAM_BYTES_DEF,
  parameter int unsigned PRG_BANKS_8K   = cbm_pkg::PRG_BANKS_8K_DEF,
  parameter int unsigned CHR_BANKS_4K   = cbm_pkg::CHR_BANKS_4K_DEF,
  localparam int unsigned WR_AW         = $clog2(WORK_RAM_BYTES)
) (
  input  cbm_pkg::in_beat_t    beat,
  input  cbm_pkg::map_state_t  state,
  output cbm_pkg::out_beat_t   res,
  output logic                 wram_rd,
  output logic                 wram_we,
  output logic [WR_AW-1:0]     wram_idx,
  output cbm_pkg::map_upd_t    upd
);

  localparam logic [14:0] WR_N  = 15'(WORK_RAM_BYTES);
  localparam logic [14:0] WR_N2 = 15'(2 * WORK_RAM_BYTES);

  logic [3:0]  page;
  logic        page_wram;
  logic [1:0]  slot;
  logic [3:0]  prg_raw;
  logic [3:0]  prg_mod;
  logic        win;
  logic [4:0]  chr_raw;
  logic [4:0]  chr_mod;
  logic        nt_sel;
  logic [14:0] wr_v0;
  logic [14:0] wr_v1;
  logic [14:0] wr_v2;
  logic [13:0] tile;

  // Bank modulo tables, worked out at elaboration
  logic [3:0] prg_mod_tbl [16];
  logic [4:0] chr_mod_tbl [32];

  for (genvar gi = 0; gi < 16; gi++) begin : g_prg_mod
    localparam int unsigned PM = gi % PRG_BANKS_8K;
    assign prg_mod_tbl[gi] = 4'(PM);
  end

  for (genvar gi = 0; gi < 32; gi++) begin : g_chr_mod
    localparam int unsigned CM = gi % CHR_BANKS_4K;
    assign chr_mod_tbl[gi] = 5'(CM);
  end

  assign page      = beat.cpu_address[15:12];
  assign page_wram = (page == cbm_pkg::PAGE_WRAM0) || (page == cbm_pkg::PAGE_WRAM1);

  // Work RAM index: 13-bit offset folded into the RAM size (quotient <= 3)
  assign wr_v0    = {2'b00, beat.cpu_address[12:0]};
  assign wr_v1    = (wr_v0 >= WR_N2) ? wr_v0 - WR_N2 : wr_v0;
  assign wr_v2    = (wr_v1 >= WR_N) ? wr_v1 - WR_N : wr_v1;
  assign wram_idx = wr_v2[WR_AW-1:0];

  // PRG: switchable slot at 0x8000, last three banks fixed
  assign slot    = beat.cpu_address[14:13];
  assign prg_raw = (slot == 2'd0) ? (state.prg_bank & state.prg_mask)
                 : (4'(state.prg_mask + {2'b00, slot} - cbm_pkg::PRG_FIXED_BIAS)
                    & state.prg_mask);
  assign prg_mod = prg_mod_tbl[prg_raw];

  // CHR: window picks one of two banks by its latch
  assign win     = beat.ppu_address[12];
  assign chr_raw = state.chr_bank[{win, state.latch[win]}] & state.chr_mask;
  assign chr_mod = chr_mod_tbl[chr_raw];

  assign nt_sel  = state.mirror_h ? beat.ppu_address[11] : beat.ppu_address[10];
  assign tile    = beat.ppu_address & cbm_pkg::PPU_TILE_MASK;

  always_comb begin
    res           = '0;
    res.read_data = cbm_pkg::OPEN_BUS;
    wram_rd       = 1'b0;
    wram_we       = 1'b0;
    upd           = '0;
    upd.page      = page;
    upd.data      = beat.write_data;

    unique case (beat.command)
      cbm_pkg::CMD_CPU_RD: begin
        if (page_wram) begin
          wram_rd = 1'b1;
        end else if (beat.cpu_address[15]) begin
          res.prg_rom_valid   = 1'b1;
          res.prg_rom_address = {prg_mod, beat.cpu_address[12:0]};
        end
      end
      cbm_pkg::CMD_CPU_WR: begin
        wram_we    = page_wram;
        upd.reg_we = (page >= cbm_pkg::PAGE_PRG_SEL);
      end
      cbm_pkg::CMD_PPU: begin
        if (beat.ppu_address < cbm_pkg::PPU_NT_BASE) begin
          res.chr_rom_valid   = 1'b1;
          res.chr_rom_address = {chr_mod, beat.ppu_address[11:0]};
        end else if (beat.ppu_address < cbm_pkg::PPU_PAL_BASE) begin
          res.nametable_valid   = 1'b1;
          res.nametable_address = {nt_sel, beat.ppu_address[9:0]};
        end
        // Latch flips after this access is translated
        priority if (tile == cbm_pkg::TILE_W0_FD) begin
          upd.latch_we = 1'b1; upd.latch_sel = 1'b0; upd.latch_val = 1'b0;
        end else if (tile == cbm_pkg::TILE_W0_FE) begin
          upd.latch_we = 1'b1; upd.latch_sel = 1'b0; upd.latch_val = 1'b1;
        end else if (tile == cbm_pkg::TILE_W1_FD) begin
          upd.latch_we = 1'b1; upd.latch_sel = 1'b1; upd.latch_val = 1'b0;
        end else if (tile == cbm_pkg::TILE_W1_FE) begin
          upd.latch_we = 1'b1; upd.latch_sel = 1'b1; upd.latch_val = 1'b1;
        end else begin
          upd.latch_we = 1'b0;
        end
      end
      default: ;
    endcase
  end

endmodule

FILE: rtl/cartridge_bank_mapper_latched_chr.sv
// Cartridge bank mapper with latched CHR windows.
// Input channel (in_valid/in_stall/in_data) takes one bus event per beat:
// a CPU read, a CPU write or a PPU address. Output channel
// (out_valid/out_stall/out_data) returns exactly one result beat per input
// beat, in order.
// Throughput: one beat per clock unless the output stalls. A result passes
// through the stage 1 register and then the output register; the work RAM's
// registered read is why stage 1 exists. Bank, latch and work RAM writes take
// effect at the accept edge, so the next beat sees them.
// A stage register between the RAM read and the output register lets a new
// beat be taken while a finished result waits; when out_stall holds, the
// result stays put and in_stall rises once the middle stage is full.
// The APB config port writes chr_bank_mask (0x0) and prg_bank_mask (0x4);
// write it only while no beat is in flight.
// Reset (rst_n low, synchronous) empties the pipeline, sets both masks to
// all ones and clears the bank, mirroring and latch registers. Work RAM is
// not cleared and reads back undefined until written.
module cartridge_bank_mapper_latched_chr #(
  parameter int unsigned WORK_RAM_BYTES = cbm_pkg::WORK_RAM_BYTES_DEF,
  parameter int unsigned PRG_BANKS_8K   = cbm_pkg::PRG_BANKS_8K_DEF,
  parameter int unsigned CHR_BANKS_4K   = cbm_pkg::CHR_BANKS_4K_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // input channel
  input  logic                        in_valid,
  output logic                        in_stall,
  input  cbm_pkg::in_beat_t           in_data,
  // output channel
  output logic                        out_valid,
  input  logic                        out_stall,
  output cbm_pkg::out_beat_t          out_data,
  // config port
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [cbm_pkg::CFG_AW-1:0]  cfg_paddr,
  input  logic [cbm_pkg::CFG_DW-1:0]  cfg_pwdata,
  output logic [cbm_pkg::CFG_DW-1:0]  cfg_prdata,
  output logic                        cfg_pready
);

  localparam int unsigned WR_AW = $clog2(WORK_RAM_BYTES);

  cbm_pkg::map_state_t map_st;
  cbm_pkg::map_upd_t   map_upd;
  cbm_pkg::out_beat_t  xl_res;
  logic                xl_wram_rd;
  logic                xl_wram_we;
  logic [WR_AW-1:0]    xl_wram_idx;
  logic [7:0]          ram_rdata;

  logic                in_accept;
  logic                s1_adv;

  logic                s1_valid_r, s1_valid_nxt;
  logic                s1_wram_r;
  cbm_pkg::out_beat_t  s1_res_r;
  logic                out_valid_r, out_valid_nxt;
  cbm_pkg::out_beat_t  out_r, out_nxt;

  // Handshake control
  assign s1_adv    = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = s1_valid_r && !s1_adv;
  assign in_accept = in_valid && !in_stall;

  cbm_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .upd_en      (in_accept),
    .upd         (map_upd),
    .state       (map_st)
  );

  cbm_xlat #(
    .WORK_RAM_BYTES (WORK_RAM_BYTES),
    .PRG_BANKS_8K   (PRG_BANKS_8K),
    .CHR_BANKS_4K   (CHR_BANKS_4K)
  ) u_xlat (
    .beat     (in_data),
    .state    (map_st),
    .res      (xl_res),
    .wram_rd  (xl_wram_rd),
    .wram_we  (xl_wram_we),
    .wram_idx (xl_wram_idx),
    .upd      (map_upd)
  );

  // Work RAM, accessed at the accept edge
  cbm_ram #(
    .WIDTH (8),
    .DEPTH (WORK_RAM_BYTES)
  ) u_wram (
    .clk   (clk),
    .en    (in_accept && (xl_wram_rd || xl_wram_we)),
    .we    (xl_wram_we),
    .addr  (xl_wram_idx),
    .wdata (in_data.write_data),
    .rdata (ram_rdata)
  );

  // Stage 1 holds the translated beat while the RAM read completes
  assign s1_valid_nxt = in_accept || (s1_valid_r && !s1_adv);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_res_r  <= xl_res;
      s1_wram_r <= xl_wram_rd;
    end
  end

  // Output register, merges RAM read data
  always_comb begin
    out_nxt = s1_res_r;
    if (s1_wram_r) begin
      out_nxt.read_data = ram_rdata;
    end
  end

  assign out_valid_nxt = s1_adv || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // At most one target space is valid per result
  a_one_target: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $countones({out_r.prg_rom_valid, out_r.chr_rom_valid,
                                out_r.nametable_valid}) <= 1)
    else $error("more than one target valid in result");

  // CHR bank stays inside the CHR ROM
  a_chr_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.chr_rom_valid) |->
      ({1'b0, out_r.chr_rom_address[16:12]} < 6'(CHR_BANKS_4K)))
    else $error("CHR bank out of range");

  // Tile 0x0FE0 sets the window 0 latch for the next beat
  a_latch_set: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && (in_data.command == cbm_pkg::CMD_PPU) &&
     ((in_data.ppu_address & cbm_pkg::PPU_TILE_MASK) == cbm_pkg::TILE_W0_FE))
    |=> map_st.latch[0])
    else $error("window 0 latch not set");

  // Middle stage never overwritten while blocked
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_adv) |=> (s1_valid_r && $stable(s1_res_r)))
    else $error("stage 1 beat lost");

endmodule

FILE: tb/tb_cartridge_bank_mapper_latched_chr.sv
module tb_cartridge_bank_mapper_latched_chr;
  timeunit 1ns;
  timeprecision 1ps;

  // Command code with no function; the mapper must leave all state alone
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int unsigned NUM_PHASES = 6;
  localparam int unsigned BEATS_PER_PHASE = 75;

  // Expected-result tracker: mirrors the mapper registers and work RAM
  class mapper_scoreboard;
    logic [4:0] chr_mask;
    logic [3:0] prg_mask;
    logic [3:0] prg_bank;
    logic [4:0] chr_bank [4];
    logic       mirror_h;
    logic       latch [2];
    logic [7:0] wram [cbm_pkg::WORK_RAM_BYTES_DEF];
    cbm_pkg::out_beat_t pending_xlat [$];
    int unsigned mismatches;
    int unsigned results_seen;

    function new();
      chr_mask = cbm_pkg::CHR_MASK_RST;
      prg_mask = cbm_pkg::PRG_MASK_RST;
      prg_bank = '0;
      foreach (chr_bank[i]) chr_bank[i] = '0;
      mirror_h = 1'b0;
      latch[0] = 1'b0;
      latch[1] = 1'b0;
      mismatches = 0;
      results_seen = 0;
    endfunction

    function void set_mask(logic idx, logic [31:0] value);
      if (idx == cbm_pkg::REG_CHR_MASK) begin
        chr_mask = value[4:0];
      end else begin
        prg_mask = value[3:0];
      end
    endfunction

    // Translate one bus event and apply its side effects
    function cbm_pkg::out_beat_t translate_access(cbm_pkg::in_beat_t b);
      cbm_pkg::out_beat_t r;
      logic [3:0] page;
      logic [3:0] bank8;
      logic [1:0] slot;
      logic [4:0] bank4;
      logic       win;
      int unsigned widx;
      r = '0;
      r.read_data = cbm_pkg::OPEN_BUS;
      page = b.cpu_address[15:12];
      widx = b.cpu_address[12:0] % cbm_pkg::WORK_RAM_BYTES_DEF;
      case (b.command)
        cbm_pkg::CMD_CPU_RD: begin
          if (page == cbm_pkg::PAGE_WRAM0 || page == cbm_pkg::PAGE_WRAM1) begin
            r.read_data = wram[widx];
          end else if (page[3]) begin
            slot = b.cpu_address[14:13];
            // slot 0 switchable, slots 1..3 fixed at mask-2, mask-1, mask
            if (slot == 2'd0) begin
              bank8 = prg_bank & prg_mask;
            end else begin
              bank8 = (prg_mask + 4'(slot) - cbm_pkg::PRG_FIXED_BIAS) & prg_mask;
            end
            bank8 = 4'(bank8 % cbm_pkg::PRG_BANKS_8K_DEF);
            r.prg_rom_valid = 1'b1;
            r.prg_rom_address = {bank8, b.cpu_address[12:0]};
          end
        end
        cbm_pkg::CMD_CPU_WR: begin
          case (page)
            cbm_pkg::PAGE_WRAM0, cbm_pkg::PAGE_WRAM1: wram[widx] = b.write_data;
            cbm_pkg::PAGE_PRG_SEL: prg_bank = b.write_data[3:0];
            cbm_pkg::PAGE_CHR0: chr_bank[0] = b.write_data[4:0];
            cbm_pkg::PAGE_CHR1: chr_bank[1] = b.write_data[4:0];
            cbm_pkg::PAGE_CHR2: chr_bank[2] = b.write_data[4:0];
            cbm_pkg::PAGE_CHR3: chr_bank[3] = b.write_data[4:0];
            cbm_pkg::PAGE_MIRROR: mirror_h = b.write_data[0];
            default: ;
          endcase
        end
        cbm_pkg::CMD_PPU: begin
          if (b.ppu_address < cbm_pkg::PPU_NT_BASE) begin
            // latch value before this access picks the bank
            win = b.ppu_address[12];
            bank4 = chr_bank[{win, latch[win]}] & chr_mask;
            bank4 = 5'(bank4 % cbm_pkg::CHR_BANKS_4K_DEF);
            r.chr_rom_valid = 1'b1;
            r.chr_rom_address = {bank4, b.ppu_address[11:0]};
          end else if (b.ppu_address < cbm_pkg::PPU_PAL_BASE) begin
            r.nametable_valid = 1'b1;
            r.nametable_address = {mirror_h ? b.ppu_address[11] : b.ppu_address[10],
                                   b.ppu_address[9:0]};
          end
          case (b.ppu_address & cbm_pkg::PPU_TILE_MASK)
            cbm_pkg::TILE_W0_FD: latch[0] = 1'b0;
            cbm_pkg::TILE_W0_FE: latch[0] = 1'b1;
            cbm_pkg::TILE_W1_FD: latch[1] = 1'b0;
            cbm_pkg::TILE_W1_FE: latch[1] = 1'b1;
            default: ;
          endcase
        end
        default: ;
      endcase
      return r;
    endfunction

    function void note_input(cbm_pkg::in_beat_t b);
      pending_xlat.push_back(translate_access(b));
    endfunction

    function void cmp_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (act_v !== exp_v) begin
        $display("%0t: %s expected %0h got %0h", $time, name, exp_v, act_v);
        mismatches++;
      end
    endfunction

    function void check_result(cbm_pkg::out_beat_t got);
      cbm_pkg::out_beat_t exp_b;
      results_seen++;
      if (pending_xlat.size() == 0) begin
        $display("%0t: unexpected result beat expected none got %p", $time, got);
        mismatches++;
        return;
      end
      exp_b = pending_xlat.pop_front();
      cmp_field("read_data", exp_b.read_data, got.read_data);
      cmp_field("prg_rom_valid", exp_b.prg_rom_valid, got.prg_rom_valid);
      cmp_field("prg_rom_address", exp_b.prg_rom_address, got.prg_rom_address);
      cmp_field("chr_rom_valid", exp_b.chr_rom_valid, got.chr_rom_valid);
      cmp_field("chr_rom_address", exp_b.chr_rom_address, got.chr_rom_address);
      cmp_field("nametable_valid", exp_b.nametable_valid, got.nametable_valid);
      cmp_field("nametable_address", exp_b.nametable_address, got.nametable_address);
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  cbm_pkg::in_beat_t in_data;
  logic out_valid;
  logic out_stall;
  cbm_pkg::out_beat_t out_data;
  logic cfg_psel;
  logic cfg_penable;
  logic cfg_pwrite;
  logic [cbm_pkg::CFG_AW-1:0] cfg_paddr;
  logic [cbm_pkg::CFG_DW-1:0] cfg_pwdata;
  logic [cbm_pkg::CFG_DW-1:0] cfg_prdata;
  logic cfg_pready;

  mapper_scoreboard board;
  bit bubbles_on;
  int unsigned beats_sent;
  int unsigned settings_run;
  // work RAM entries written so far; reads only target these
  bit wram_filled [cbm_pkg::WORK_RAM_BYTES_DEF];
  logic [12:0] wram_filled_q [$];

  cartridge_bank_mapper_latched_chr dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      board.check_result(out_data);
    end
  end

  // Receiver backpressure in random bursts
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (bubbles_on && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 9)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog
  initial begin
    #3_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // One input beat, with an optional idle burst ahead of it
  task automatic send_beat(cbm_pkg::in_beat_t b);
    logic [12:0] widx;
    widx = b.cpu_address[12:0];
    if (bubbles_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= b;
    do @(posedge clk); while (in_stall);
    board.note_input(b);
    beats_sent++;
    if (b.command == cbm_pkg::CMD_CPU_WR &&
        (b.cpu_address[15:12] == cbm_pkg::PAGE_WRAM0 ||
         b.cpu_address[15:12] == cbm_pkg::PAGE_WRAM1) && !wram_filled[widx]) begin
      wram_filled[widx] = 1'b1;
      wram_filled_q.push_back(widx);
    end
  endtask

  task automatic bus_beat(logic [1:0] cmd, logic [15:0] caddr, logic [7:0] wdata,
                          logic [13:0] paddr);
    cbm_pkg::in_beat_t b;
    b.command = cmd;
    b.cpu_address = caddr;
    b.write_data = wdata;
    b.ppu_address = paddr;
    send_beat(b);
  endtask

  // Drop valid and wait for every outstanding result
  task automatic drain_results();
    in_valid <= 1'b0;
    while (board.pending_xlat.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // APB write followed by a readback of the same register
  task automatic cfg_set(logic idx, logic [31:0] value);
    logic [31:0] rd;
    logic [31:0] keep;
    keep = (idx == cbm_pkg::REG_CHR_MASK) ? 32'h1F : 32'h0F;
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    board.set_mask(idx, value);
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rd = cfg_prdata;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    // bus goes idle before the next transfer
    @(posedge clk);
    if ((rd & keep) !== (value & keep)) begin
      $display("%0t: mask register %0d expected %0h got %0h", $time, idx,
               value & keep, rd & keep);
      board.mismatches++;
    end
  endtask

  // Random bus event, biased toward mapped ranges and latch tiles
  function automatic cbm_pkg::in_beat_t random_access();
    cbm_pkg::in_beat_t b;
    logic [13:0] tiles [4];
    int pick;
    tiles = '{cbm_pkg::TILE_W0_FD, cbm_pkg::TILE_W0_FE,
              cbm_pkg::TILE_W1_FD, cbm_pkg::TILE_W1_FE};
    b.command = CMD_UNUSED;
    b.cpu_address = 16'($urandom);
    b.write_data = 8'($urandom);
    b.ppu_address = 14'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 25) begin
      b.command = cbm_pkg::CMD_CPU_RD;
      case ($urandom_range(0, 2))
        0: begin
          if (wram_filled_q.size() != 0) begin
            b.cpu_address = 16'h6000 |
                wram_filled_q[$urandom_range(0, wram_filled_q.size() - 1)];
          end else begin
            b.cpu_address = 16'($urandom_range(16'h8000, 16'hFFFF));
          end
        end
        1: b.cpu_address = 16'($urandom_range(16'h8000, 16'hFFFF));
        default: b.cpu_address = 16'($urandom_range(0, 16'h5FFF));
      endcase
    end else if (pick < 50) begin
      b.command = cbm_pkg::CMD_CPU_WR;
      case ($urandom_range(0, 3))
        0, 1: b.cpu_address = {4'($urandom_range(cbm_pkg::PAGE_PRG_SEL,
                                                 cbm_pkg::PAGE_MIRROR)),
                               12'($urandom)};
        2: b.cpu_address = 16'h6000 | 16'($urandom_range(0, 16'h1FFF));
        default: begin
          if ($urandom_range(0, 1) == 0) begin
            b.cpu_address = 16'($urandom_range(0, 16'h5FFF));
          end else begin
            b.cpu_address = 16'($urandom_range(16'h8000, 16'h9FFF));
          end
        end
      endcase
    end else if (pick < 95) begin
      b.command = cbm_pkg::CMD_PPU;
      case ($urandom_range(0, 4))
        0: b.ppu_address = tiles[$urandom_range(0, 3)] | 14'($urandom_range(0, 15));
        1: b.ppu_address = 14'($urandom_range(0, 14'h1FFF));
        2: b.ppu_address = 14'($urandom_range(cbm_pkg::PPU_NT_BASE,
                                               cbm_pkg::PPU_PAL_BASE - 1));
        3: b.ppu_address = 14'($urandom_range(cbm_pkg::PPU_PAL_BASE, 14'h3FFF));
        default: ;
      endcase
    end
    return b;
  endfunction

  // Stimulus
  initial begin
    logic [4:0] chr_set [NUM_PHASES];
    logic [3:0] prg_set [NUM_PHASES];
    int unsigned directed_n;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    bubbles_on = 1'b1;
    beats_sent = 0;
    settings_run = 1;
    board = new();
    chr_set = '{5'd0, 5'd31, 5'd5, 5'd16, 5'($urandom), 5'd31};
    prg_set = '{4'd3, 4'd15, 4'd7, 4'd4, 4'($urandom_range(3, 15)), 4'd15};
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset masks, every range and the latch tiles
    bus_beat(cbm_pkg::CMD_CPU_RD, 16'h0000, 8'h00, 14'h0000);   // unmapped read
    bus_beat(cbm_pkg::CMD_CPU_WR, 16'h6000, 8'hA5, 14'h3FFF);
    bus_beat(cbm_pkg::CMD_CPU_WR, 16'h7FFF, 8'h5A, 14'h0000);
    bus_beat(cbm_pkg::CMD_CPU_RD, 16'h6000, 8'hFF, 14'h0000);
    bus_beat(cbm_pkg::CMD_CPU_RD, 16'h7FFF, 8'h00, 14'h0000);
    bus_beat(cbm_pkg::CMD_CPU_WR, 16'hA000, 8'hFF, 14'h0000);   // PRG bank keeps 4 bits
    bus_beat(cbm_pkg::CMD_CPU_RD, 16'h8000, 8'h00, 14'h0000);
    bus_beat(cbm_pkg::CMD_CPU_RD, 16'hBFFF, 8'h00, 14'h0000);
    bus_beat(cbm_pkg::CMD_CPU_RD, 16'hFFFF, 8'h00, 14'h0000);
    bus_beat(cbm_pkg::CMD_CPU_WR, 16'hB000, 8'hE1, 14'h0000);   // CHR banks keep 5 bits
    bus_beat(cbm_pkg::CMD_CPU_WR, 16'hCFFF, 8'h1E, 14'h0000);
    bus_beat(cbm_pkg::CMD_CPU_WR, 16'hD000, 8'h03, 14'h0000);
    bus_beat(cbm_pkg::CMD_CPU_WR, 16'hEFFF, 8'hFF, 14'h0000);
    bus_beat(cbm_pkg::CMD_CPU_WR, 16'h8000, 8'h77, 14'h0000);   // ignored write
    bus_beat(cbm_pkg::CMD_PPU, 16'h0000, 8'h00, 14'h0FE8);      // latch 0 flips after
    bus_beat(cbm_pkg::CMD_PPU, 16'h0000, 8'h00, 14'h0ABC);
    bus_beat(cbm_pkg::CMD_PPU, 16'h0000, 8'h00, 14'h1FDF);
    bus_beat(cbm_pkg::CMD_PPU, 16'h0000, 8'h00, 14'h1FE0);
    bus_beat(cbm_pkg::CMD_PPU, 16'h0000, 8'h00, 14'h1FFF);
    bus_beat(cbm_pkg::CMD_PPU, 16'h0000, 8'h00, 14'h0FD0);
    bus_beat(cbm_pkg::CMD_CPU_WR, 16'hF000, 8'hFF, 14'h0000);   // horizontal mirroring
    bus_beat(cbm_pkg::CMD_PPU, 16'h0000, 8'h00, 14'h2C00);
    bus_beat(cbm_pkg::CMD_PPU, 16'h0000, 8'h00, 14'h3EFF);
    bus_beat(cbm_pkg::CMD_PPU, 16'h0000, 8'h00, 14'h3F00);      // palette, nothing valid
    bus_beat(CMD_UNUSED, 16'hFFFF, 8'hFF, 14'h3FFF);
    directed_n = beats_sent;

    // Random phases, one mask setting each
    for (int p = 0; p < NUM_PHASES; p++) begin
      drain_results();
      cfg_set(cbm_pkg::REG_CHR_MASK, 32'(chr_set[p]));
      cfg_set(cbm_pkg::REG_PRG_MASK, 32'(prg_set[p]));
      settings_run++;
      for (int n = 0; n < BEATS_PER_PHASE; n++) begin
        if (n % 25 == 0) begin
          bubbles_on = (p != NUM_PHASES - 1) && ($urandom_range(0, 3) != 0);
        end
        send_beat(random_access());
      end
    end
    drain_results();

    $display("Sent %0d bus beats (%0d directed) under %0d mask settings.",
             beats_sent, directed_n, settings_run);
    $display("Compared %0d result beats; %0d work RAM bytes written.",
             board.results_seen, wram_filled_q.size());
    if (board.mismatches == 0 && board.pending_xlat.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/cbm_pkg.sv
rtl/cbm_ram.sv
rtl/cbm_regs.sv
rtl/cbm_xlat.sv
rtl/cartridge_bank_mapper_latched_chr.sv
tb/tb_cartridge_bank_mapper_latched_chr.sv
